[rtl/hte_pkg.sv]
// Package for the handle table engine: sizes, entry layout, command and
// state codes, and the control/status records shared by the modules.
// No dependencies.
package hte_pkg;

    localparam int TABLE_SIZE = 64;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int SLOT_W     = 8;
    localparam int RES_W      = 6;
    localparam int KIND_W     = 4;
    localparam int OBJ_W      = 64;
    localparam int WORD_W     = 32;
    localparam int META_W     = 64;

    // Table size as an unsigned value one bit wider than the slot field.
    localparam logic [SLOT_W:0] TABLE_LIMIT = (SLOT_W + 1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_SIZE - 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OBJ_W-1:0]  object;
        logic [WORD_W-1:0] rights;
        logic [WORD_W-1:0] flags;
        logic [META_W-1:0] meta;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic start;
        logic add_mode;
    } scan_ctrl_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } scan_stat_t;

    // Low RES_W bits of an entry index, zero-extended when the index is narrower.
    function automatic logic [RES_W-1:0] to_res(input logic [IDX_W-1:0] idx);
        logic [IDX_W+RES_W-1:0] wide;
        wide = {{RES_W{1'b0}}, idx};
        return wide[RES_W-1:0];
    endfunction

endpackage

[rtl/hte_if.sv]
// Handshake interfaces for the request and response channels of the
// handle table engine. Depends on hte_pkg.
interface hte_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  command;
    logic [hte_pkg::SLOT_W-1:0]  slot_index;
    logic [hte_pkg::OBJ_W-1:0]   object_ref;
    logic [hte_pkg::KIND_W-1:0]  entry_kind;
    logic [hte_pkg::WORD_W-1:0]  rights_in;
    logic [hte_pkg::WORD_W-1:0]  flags_in;
    logic [hte_pkg::META_W-1:0]  meta_in;

    modport source (output valid, command, slot_index, object_ref, entry_kind,
                    rights_in, flags_in, meta_in, input ready);
    modport sink   (input valid, command, slot_index, object_ref, entry_kind,
                    rights_in, flags_in, meta_in, output ready);
endinterface

interface hte_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        success;
    logic [hte_pkg::RES_W-1:0]   result_index;
    logic [hte_pkg::KIND_W-1:0]  out_kind;
    logic [hte_pkg::OBJ_W-1:0]   out_object;
    logic [hte_pkg::WORD_W-1:0]  out_rights;
    logic [hte_pkg::WORD_W-1:0]  out_flags;
    logic [hte_pkg::META_W-1:0]  out_meta;

    modport source (output valid, success, result_index, out_kind, out_object,
                    out_rights, out_flags, out_meta, input ready);
    modport sink   (input valid, success, result_index, out_kind, out_object,
                    out_rights, out_flags, out_meta, output ready);
endinterface

[rtl/hte_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module hte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/hte_scan.sv]
// Shared scan unit: walks the table one entry per cycle, looking for the
// first free entry or the first valid entry holding an object.
// Depends on hte_pkg.
module hte_scan (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hte_pkg::scan_ctrl_t          ctrl,
    input  logic [hte_pkg::OBJ_W-1:0]    obj,
    input  logic [hte_pkg::TABLE_SIZE-1:0] valid,
    input  logic [hte_pkg::OBJ_W-1:0]    entry_obj,
    output logic                         rd_en,
    output logic [hte_pkg::IDX_W-1:0]    rd_addr,
    output hte_pkg::scan_stat_t          stat
);

    logic                      active_reg;
    logic                      add_reg;
    logic [hte_pkg::IDX_W-1:0] issue_reg;
    logic [hte_pkg::IDX_W-1:0] look_reg;
    logic                      done_reg;
    logic                      hit_reg;
    logic [hte_pkg::IDX_W-1:0] idx_reg;
    logic                      match;
    logic                      last;

    // The address runs one entry ahead of the compare, covering the RAM read latency.
    assign rd_en   = ctrl.start | active_reg;
    assign rd_addr = ctrl.start ? '0 : issue_reg;

    assign last  = (look_reg == hte_pkg::LAST_IDX);
    assign match = add_reg ? !valid[look_reg]
                           : (valid[look_reg] && (entry_obj == obj));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            add_reg    <= 1'b0;
            issue_reg  <= '0;
            look_reg   <= '0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                active_reg <= 1'b1;
                add_reg    <= ctrl.add_mode;
                look_reg   <= '0;
                issue_reg  <= hte_pkg::IDX_W'(1);
            end
            else if (active_reg)
            begin
                if (match || last)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                    hit_reg    <= match;
                    idx_reg    <= look_reg;
                end
                else
                begin
                    look_reg  <= issue_reg;
                    issue_reg <= issue_reg + hte_pkg::IDX_W'(1);
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.hit  = hit_reg;
    assign stat.idx  = idx_reg;

endmodule

[rtl/handle_table_engine_unit.sv]
// Top level of the handle table engine: command sequencer, free/valid map,
// entry RAM and response register. Depends on hte_pkg, hte_if, hte_ram, hte_scan.
//
//   Channel  Direction  Handshake     Carries
//   req      in         valid/ready   command, slot_index, object_ref, entry_kind,
//                                     rights_in, flags_in, meta_in
//   rsp      out        valid/ready   success, result_index, out_kind, out_object,
//                                     out_rights, out_flags, out_meta
//
// Remove, get and a zero-object find go straight from ST_IDLE to ST_DONE, where the
// response is loaded once the output register is free. Add and find first scan in ST_SCAN,
// one entry per cycle, stopping at the first hit. Reset clears the valid map in one step.
// A new item is accepted while a response waits in the output register; the next
// finished response then holds in ST_DONE, with the input not ready, until it is taken.
module handle_table_engine_unit (
    input  logic      clk,
    input  logic      rst_n,
    hte_req_if.sink   req,
    hte_rsp_if.source rsp
);

    hte_pkg::state_t state_reg, state_next;

    // One bit per entry: set by an add of nonzero kind, cleared by a remove.
    logic [hte_pkg::TABLE_SIZE-1:0] valid_reg, valid_next;

    // The accepted item, held for the whole command.
    logic [1:0]                  cmd_reg;
    logic [hte_pkg::OBJ_W-1:0]   obj_reg;
    logic [hte_pkg::KIND_W-1:0]  kind_reg;
    logic [hte_pkg::WORD_W-1:0]  rights_reg;
    logic [hte_pkg::WORD_W-1:0]  flags_reg;
    logic [hte_pkg::META_W-1:0]  meta_reg;

    // Pending result, moved into the response register in ST_DONE.
    logic                       res_ok_reg, res_ok_next;
    logic [hte_pkg::RES_W-1:0]  res_idx_reg, res_idx_next;
    logic                       res_get_reg, res_get_next;

    logic                        rsp_valid_reg;
    logic                        rsp_ok_reg;
    logic [hte_pkg::RES_W-1:0]   rsp_idx_reg;
    hte_pkg::entry_t             rsp_entry_reg;

    hte_pkg::scan_ctrl_t         scan_ctrl;
    hte_pkg::scan_stat_t         scan_stat;
    logic                        scan_rd_en;
    logic [hte_pkg::IDX_W-1:0]   scan_rd_addr;

    logic                        ram_we;
    logic                        ram_re;
    logic [hte_pkg::IDX_W-1:0]   ram_raddr;
    logic [hte_pkg::ENTRY_W-1:0] ram_rdata;
    hte_pkg::entry_t             rd_entry;
    hte_pkg::entry_t             wr_entry;

    logic                        accept;
    logic                        get_rd;
    logic                        out_free;
    logic                        load_rsp;
    logic                        slot_in_range;
    logic [hte_pkg::IDX_W-1:0]   slot_idx;
    logic                        slot_hit;

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign load_rsp = (state_reg == hte_pkg::ST_DONE) && out_free;

    // A slot names a live entry only if it is inside the table and valid.
    assign slot_in_range = ({1'b0, req.slot_index} < hte_pkg::TABLE_LIMIT);
    assign slot_idx      = req.slot_index[hte_pkg::IDX_W-1:0];
    assign slot_hit      = slot_in_range && valid_reg[slot_idx];

    assign rd_entry = hte_pkg::entry_t'(ram_rdata);
    assign wr_entry = '{kind: kind_reg, object: obj_reg, rights: rights_reg,
                        flags: flags_reg, meta: meta_reg};

    assign ram_re    = get_rd | scan_rd_en;
    assign ram_raddr = get_rd ? slot_idx : scan_rd_addr;

    hte_ram #(
        .WIDTH (hte_pkg::ENTRY_W),
        .DEPTH (hte_pkg::TABLE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (scan_stat.idx),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hte_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .obj       (obj_reg),
        .valid     (valid_reg),
        .entry_obj (rd_entry.object),
        .rd_en     (scan_rd_en),
        .rd_addr   (scan_rd_addr),
        .stat      (scan_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hte_pkg::ST_IDLE;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.command;
            obj_reg    <= req.object_ref;
            kind_reg   <= req.entry_kind;
            rights_reg <= req.rights_in;
            flags_reg  <= req.flags_in;
            meta_reg   <= req.meta_in;
        end
        res_ok_reg  <= res_ok_next;
        res_idx_reg <= res_idx_next;
        res_get_reg <= res_get_next;
        if (load_rsp)
        begin
            rsp_ok_reg    <= res_ok_reg;
            rsp_idx_reg   <= res_idx_reg;
            rsp_entry_reg <= res_get_reg ? rd_entry : '0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        res_ok_next  = res_ok_reg;
        res_idx_next = res_idx_reg;
        res_get_next = res_get_reg;
        scan_ctrl    = '0;
        get_rd       = 1'b0;
        ram_we       = 1'b0;
        req.ready    = (state_reg == hte_pkg::ST_IDLE);

        case (state_reg)
            hte_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_ok_next  = 1'b0;
                    res_idx_next = '0;
                    res_get_next = 1'b0;
                    state_next   = hte_pkg::ST_DONE;
                    case (hte_pkg::cmd_e'(req.command))
                        hte_pkg::CMD_ADD:
                        begin
                            scan_ctrl.start    = 1'b1;
                            scan_ctrl.add_mode = 1'b1;
                            state_next         = hte_pkg::ST_SCAN;
                        end
                        hte_pkg::CMD_REMOVE:
                        begin
                            if (slot_hit)
                            begin
                                valid_next[slot_idx] = 1'b0;
                                res_ok_next          = 1'b1;
                                res_idx_next         = hte_pkg::to_res(slot_idx);
                            end
                        end
                        hte_pkg::CMD_GET:
                        begin
                            // The entry is read at this edge and held in the RAM output.
                            if (slot_hit)
                            begin
                                get_rd       = 1'b1;
                                res_ok_next  = 1'b1;
                                res_idx_next = hte_pkg::to_res(slot_idx);
                                res_get_next = 1'b1;
                            end
                        end
                        hte_pkg::CMD_FIND:
                        begin
                            // The zero object never matches.
                            if (req.object_ref != '0)
                            begin
                                scan_ctrl.start = 1'b1;
                                state_next      = hte_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = hte_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            hte_pkg::ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    res_ok_next  = scan_stat.hit;
                    res_idx_next = scan_stat.hit ? hte_pkg::to_res(scan_stat.idx) : '0;
                    // An add of kind zero is written but leaves the entry free.
                    if (scan_stat.hit && (hte_pkg::cmd_e'(cmd_reg) == hte_pkg::CMD_ADD))
                    begin
                        ram_we = 1'b1;
                        if (kind_reg != '0)
                        begin
                            valid_next[scan_stat.idx] = 1'b1;
                        end
                    end
                    state_next = hte_pkg::ST_DONE;
                end
            end
            hte_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = hte_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hte_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.success      = rsp_ok_reg;
    assign rsp.result_index = rsp_idx_reg;
    assign rsp.out_kind     = rsp_entry_reg.kind;
    assign rsp.out_object   = rsp_entry_reg.object;
    assign rsp.out_rights   = rsp_entry_reg.rights;
    assign rsp.out_flags    = rsp_entry_reg.flags;
    assign rsp.out_meta     = rsp_entry_reg.meta;

endmodule
